### rtl/positional_list_insert_delete_macros.svh
// assertion macros for the positional list block
// used by the port checker, no other dependencies
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// condition in the same cycle implies consequence
`define PLID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list check failed");

// condition implies consequence in the next cycle
`define PLID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list check failed");

`endif

### rtl/plid_pkg.sv
// shared types, widths and codes for the positional list block
// no dependencies
package plid_pkg;

  // list size and derived widths
  localparam int CAPACITY  = 16;
  localparam int EntryW    = 16;
  localparam int CntW      = $clog2(CAPACITY + 1);
  localparam int IdxW      = $clog2(CAPACITY);
  localparam int FuncW     = 3;
  localparam int PosW      = 5;
  localparam int StatusW   = 2;
  localparam int CntFieldW = 5;
  localparam int CmpW      = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef logic [EntryW-1:0]    entry_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [FuncW-1:0]     func_t;
  typedef logic [PosW-1:0]      pos_t;
  typedef logic [StatusW-1:0]   status_t;
  typedef logic [CntFieldW-1:0] cnt_field_t;
  typedef logic [CmpW-1:0]      cmp_t;

  // request codes
  localparam func_t FUNC_INS_FRONT = 3'd0;
  localparam func_t FUNC_INS_END   = 3'd1;
  localparam func_t FUNC_INS_POS   = 3'd2;
  localparam func_t FUNC_DEL_POS   = 3'd3;
  localparam func_t FUNC_READ      = 3'd4;

  // result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_BADPOS = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   del;
    idx_t   idx;
    entry_t value;
  } cmd_t;

  // per-request outcome from the controller
  typedef struct packed {
    status_t status;
    cnt_t    count;
    logic    take;
  } res_t;

endpackage

### rtl/positional_list_insert_delete.sv
// Positional list of up to CAPACITY 16-bit entries with insert at front, end or position,
// delete at position and read at position. One request is taken every clock cycle unless the
// output stalls; its result appears in the output register on the next cycle. All slots sit
// in a row of cells that shift together on the edge that takes the request; a new beat is
// taken whenever the output register is empty or being drained in the same cycle.
// Depends on plid_pkg, plid_ctrl and plid_cell.
module positional_list_insert_delete (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  plid_pkg::func_t       func_i,
  input  plid_pkg::pos_t        position_i,
  input  plid_pkg::entry_t      room_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output plid_pkg::status_t     status_o,
  output plid_pkg::cnt_field_t  entry_count_o,
  output plid_pkg::entry_t      read_value_o
);

  logic              fire;
  logic              out_valid_q;
  plid_pkg::cmd_t    cmd;
  plid_pkg::res_t    res;
  plid_pkg::entry_t  entries [plid_pkg::CAPACITY];
  plid_pkg::entry_t  rdata;
  plid_pkg::status_t status_q;
  plid_pkg::cnt_field_t count_q;
  plid_pkg::entry_t  read_value_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  plid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .func_i     (func_i),
    .position_i (position_i),
    .room_i     (room_i),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  // row of slots, each wired to its neighbours
  for (genvar k = 0; k < plid_pkg::CAPACITY; k++) begin : g_cell
    plid_pkg::entry_t left, right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entries[k-1];
    end
    if (k == plid_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entries[k+1];
    end
    plid_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (plid_pkg::idx_t'(k)),
      .cmd_i      (cmd),
      .left_i     (left),
      .right_i    (right),
      .entry_o    (entries[k])
    );
  end

  // entry at the requested slot, before any shift
  assign rdata = entries[cmd.idx];

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q     <= res.status;
      count_q      <= plid_pkg::cnt_field_t'(res.count);
      read_value_q <= res.take ? rdata : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign read_value_o  = read_value_q;

endmodule

### rtl/plid_cell.sv
// one list slot: holds an entry and shifts with its neighbours
// depends on plid_pkg
module plid_cell (
  input  logic            clk_i,
  input  plid_pkg::idx_t  cell_idx_i,
  input  plid_pkg::cmd_t  cmd_i,
  input  plid_pkg::entry_t left_i,
  input  plid_pkg::entry_t right_i,
  output plid_pkg::entry_t entry_o
);

  plid_pkg::entry_t entry_d, entry_q;

  // insert moves later slots back, delete pulls later slots forward
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (cell_idx_i > cmd_i.idx) begin
        entry_d = left_i;
      end else if (cell_idx_i == cmd_i.idx) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      if (cell_idx_i >= cmd_i.idx) begin
        entry_d = right_i;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/plid_ctrl.sv
// request decode, range checks and entry count for the positional list
// depends on plid_pkg
module plid_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  plid_pkg::func_t   func_i,
  input  plid_pkg::pos_t    position_i,
  input  plid_pkg::entry_t  room_i,
  output plid_pkg::cmd_t    cmd_o,
  output plid_pkg::res_t    res_o
);

  plid_pkg::cnt_t  count_d, count_q;
  plid_pkg::cmp_t  cnt_c, pos_c, pos_m1;
  plid_pkg::idx_t  idx;
  plid_pkg::status_t status;
  logic            full, ins_pos_ok, sel_pos_ok, ins, del, take;

  // decode the request and check it against the count
  always_comb begin
    cnt_c      = plid_pkg::cmp_t'(count_q);
    pos_c      = plid_pkg::cmp_t'(position_i);
    pos_m1     = pos_c - plid_pkg::cmp_t'(1);
    full       = (count_q == plid_pkg::cnt_t'(plid_pkg::CAPACITY));
    ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + plid_pkg::cmp_t'(1));
    sel_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
    ins        = 1'b0;
    del        = 1'b0;
    take       = 1'b0;
    status     = plid_pkg::ST_OK;
    idx        = plid_pkg::idx_t'(pos_m1);
    unique case (func_i)
      plid_pkg::FUNC_INS_FRONT: begin
        if (full) begin
          status = plid_pkg::ST_FULL;
        end else begin
          ins = 1'b1;
          idx = '0;
        end
      end
      plid_pkg::FUNC_INS_END: begin
        if (full) begin
          status = plid_pkg::ST_FULL;
        end else begin
          ins = 1'b1;
          idx = plid_pkg::idx_t'(count_q);
        end
      end
      plid_pkg::FUNC_INS_POS: begin
        if (full) begin
          status = plid_pkg::ST_FULL;
        end else if (!ins_pos_ok) begin
          status = plid_pkg::ST_BADPOS;
        end else begin
          ins = 1'b1;
        end
      end
      plid_pkg::FUNC_DEL_POS: begin
        if (!sel_pos_ok) begin
          status = plid_pkg::ST_BADPOS;
        end else begin
          del  = 1'b1;
          take = 1'b1;
        end
      end
      plid_pkg::FUNC_READ: begin
        if (!sel_pos_ok) begin
          status = plid_pkg::ST_BADPOS;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        status = plid_pkg::ST_BADPOS;
      end
    endcase
  end

  // count after this request
  always_comb begin
    count_d = count_q;
    if (ins) begin
      count_d = count_q + plid_pkg::cnt_t'(1);
    end else if (del) begin
      count_d = count_q - plid_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  // shift command goes out only on an accepted beat
  assign cmd_o.ins    = ins & fire_i;
  assign cmd_o.del    = del & fire_i;
  assign cmd_o.idx    = idx;
  assign cmd_o.value  = room_i;
  assign res_o.status = status;
  assign res_o.count  = count_d;
  assign res_o.take   = take;

endmodule

### rtl/positional_list_insert_delete_checker.sv
// port-level checks for the positional list block, bound to the top level
// depends on plid_pkg and positional_list_insert_delete_macros.svh
`include "positional_list_insert_delete_macros.svh"

module positional_list_insert_delete_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input plid_pkg::status_t     status_o,
  input plid_pkg::cnt_field_t  entry_count_o,
  input plid_pkg::entry_t      read_value_o
);

  localparam plid_pkg::cnt_field_t FULL_COUNT = plid_pkg::cnt_field_t'(plid_pkg::CAPACITY);

  logic fail_beat, full_beat, status_known, stall_beat;
  logic [plid_pkg::StatusW+plid_pkg::CntFieldW+plid_pkg::EntryW-1:0] out_beat;

  // result beat views used by the checks below
  assign fail_beat    = out_valid_o && (status_o != plid_pkg::ST_OK);
  assign full_beat    = out_valid_o && (status_o == plid_pkg::ST_FULL);
  assign status_known = (status_o == plid_pkg::ST_OK) || (status_o == plid_pkg::ST_FULL) ||
                        (status_o == plid_pkg::ST_BADPOS);
  assign stall_beat   = out_valid_o && !out_ready_i;
  assign out_beat     = {status_o, entry_count_o, read_value_o};

  // every accepted beat gives a result on the next cycle
  `PLID_ASSERT_NEXT(a_accept_result, in_valid_i && in_ready_o, out_valid_o)

  // failed requests return no value
  `PLID_ASSERT_SAME(a_fail_no_value, fail_beat, read_value_o == '0)

  // a full report means the list holds its capacity
  `PLID_ASSERT_SAME(a_full_count, full_beat, entry_count_o == FULL_COUNT)

  // only the three defined status codes appear
  `PLID_ASSERT_SAME(a_status_code, out_valid_o, status_known)

  // stalled result holds its value
  `PLID_ASSERT_NEXT(a_stall_hold, stall_beat, out_valid_o && $stable(out_beat))

endmodule

bind positional_list_insert_delete positional_list_insert_delete_checker u_checker (.*);

### tb/positional_list_insert_delete_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the positional list block: directed table, then random phases
// depends on plid_pkg and positional_list_insert_delete
module positional_list_insert_delete_tb;

  // function codes that the block must reject
  localparam plid_pkg::func_t FUNC_RSVD5 = 3'd5;
  localparam plid_pkg::func_t FUNC_RSVD6 = 3'd6;
  localparam plid_pkg::func_t FUNC_RSVD7 = 3'd7;

  localparam int NUM_DIR        = 24;
  localparam int NUM_PHASES     = 25;
  localparam int PHASE_ITEMS    = 50;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  // phase kinds of the random part
  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIXED = 2;
  localparam int PH_NOISE = 3;

  typedef struct packed {
    plid_pkg::status_t    status;
    plid_pkg::cnt_field_t count;
    plid_pkg::entry_t     value;
  } list_result_t;

  typedef struct packed {
    plid_pkg::func_t  f;
    plid_pkg::pos_t   p;
    plid_pkg::entry_t v;
    logic             typed;
    list_result_t     want;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  plid_pkg::func_t      func_i      = '0;
  plid_pkg::pos_t       position_i  = '0;
  plid_pkg::entry_t     room_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  plid_pkg::status_t    status_o;
  plid_pkg::cnt_field_t entry_count_o;
  plid_pkg::entry_t     read_value_o;

  // shadow copy of the list
  plid_pkg::entry_t shadow_list [plid_pkg::CAPACITY];
  int               shadow_count = 0;

  list_result_t pending_results [$];
  dir_row_t     dir_rows [NUM_DIR];

  int  error_count     = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  full_seen       = 0;
  int  badpos_seen     = 0;
  int  rcv_gap_max     = 12;
  bit  hold_request    = 1'b0;
  int  holds_done      = 0;

  positional_list_insert_delete dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .position_i    (position_i),
    .room_i        (room_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .read_value_o  (read_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // applies one request to the shadow list and returns its result
  function automatic list_result_t list_update(plid_pkg::func_t f, plid_pkg::pos_t p,
                                               plid_pkg::entry_t v);
    list_result_t r;
    int slot;
    int k;
    r.status = plid_pkg::ST_OK;
    r.value  = '0;
    case (f) inside
      plid_pkg::FUNC_INS_FRONT, plid_pkg::FUNC_INS_END, plid_pkg::FUNC_INS_POS: begin
        if (shadow_count >= plid_pkg::CAPACITY) begin
          r.status = plid_pkg::ST_FULL;
        end else begin
          if (f == plid_pkg::FUNC_INS_FRONT) slot = 0;
          else if (f == plid_pkg::FUNC_INS_END) slot = shadow_count;
          else if (int'(p) < 1 || int'(p) > shadow_count + 1) slot = -1;
          else slot = int'(p) - 1;
          if (slot < 0) begin
            r.status = plid_pkg::ST_BADPOS;
          end else begin
            for (k = shadow_count; k > slot; k--) shadow_list[k] = shadow_list[k-1];
            shadow_list[slot] = v;
            shadow_count++;
          end
        end
      end
      plid_pkg::FUNC_DEL_POS, plid_pkg::FUNC_READ: begin
        if (int'(p) < 1 || int'(p) > shadow_count) begin
          r.status = plid_pkg::ST_BADPOS;
        end else begin
          r.value = shadow_list[int'(p) - 1];
          if (f == plid_pkg::FUNC_DEL_POS) begin
            for (k = int'(p) - 1; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k+1];
            shadow_count--;
          end
        end
      end
      default: r.status = plid_pkg::ST_BADPOS;
    endcase
    r.count = plid_pkg::cnt_field_t'(shadow_count);
    return r;
  endfunction

  // offers one request after a gap and records its expected result once accepted
  task automatic send_item(input plid_pkg::func_t f, input plid_pkg::pos_t p,
                           input plid_pkg::entry_t v, input int gap,
                           input logic typed, input list_result_t want);
    list_result_t predicted;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    position_i <= p;
    room_i     <= v;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = list_update(f, p, v);
    if (typed) predicted = want;
    if (predicted.status == plid_pkg::ST_FULL) full_seen++;
    if (predicted.status == plid_pkg::ST_BADPOS) badpos_seen++;
    pending_results.push_back(predicted);
    items_sent++;
  endtask

  // result side: random stalls, one long hold-off on request, checks each beat
  initial begin
    list_result_t want;
    int stall;
    wait (rst_ni);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        stall = $urandom_range(0, rcv_gap_max);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result beat: status %0d count %0d value %h",
                   status_o, entry_count_o, read_value_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || entry_count_o !== want.count ||
            read_value_o !== want.value) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch at result %0d: expected status %0d count %0d value %h, ",
                      "got status %0d count %0d value %h"},
                     results_checked, want.status, want.count, want.value,
                     status_o, entry_count_o, read_value_o);
        end
        results_checked++;
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int               phase;
    int               n;
    int               kind;
    int               drv_gap_max;
    int               pick;
    int               lim;
    plid_pkg::func_t  f;
    plid_pkg::pos_t   p;
    plid_pkg::entry_t v;

    // directed rows: empty list, rejected codes, front and end via position, bad positions
    // (the full list is reached in the fill phases)
    dir_rows = '{
      {plid_pkg::FUNC_READ,      5'd1,  16'h0000, 1'b1, plid_pkg::ST_BADPOS, 5'd0, 16'h0000},
      {plid_pkg::FUNC_DEL_POS,   5'd1,  16'h0000, 1'b1, plid_pkg::ST_BADPOS, 5'd0, 16'h0000},
      {FUNC_RSVD5,               5'd1,  16'h0001, 1'b1, plid_pkg::ST_BADPOS, 5'd0, 16'h0000},
      {FUNC_RSVD6,               5'd31, 16'hFFFF, 1'b1, plid_pkg::ST_BADPOS, 5'd0, 16'h0000},
      {FUNC_RSVD7,               5'd0,  16'h8000, 1'b1, plid_pkg::ST_BADPOS, 5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd0,  16'h1111, 1'b1, plid_pkg::ST_BADPOS, 5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd2,  16'h2222, 1'b1, plid_pkg::ST_BADPOS, 5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_FRONT, 5'd31, 16'hFFFF, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_END,   5'd0,  16'h0000, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd1,  16'hA5A5, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd4,  16'h5A5A, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd3,  16'h1234, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd0,  16'h3333, 1'b1, plid_pkg::ST_BADPOS, 5'd5, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd7,  16'h4444, 1'b1, plid_pkg::ST_BADPOS, 5'd5, 16'h0000},
      {plid_pkg::FUNC_INS_POS,   5'd31, 16'hFFFF, 1'b1, plid_pkg::ST_BADPOS, 5'd5, 16'h0000},
      {plid_pkg::FUNC_READ,      5'd1,  16'hFFFF, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_READ,      5'd5,  16'h0000, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_READ,      5'd6,  16'h0000, 1'b1, plid_pkg::ST_BADPOS, 5'd5, 16'h0000},
      {plid_pkg::FUNC_READ,      5'd0,  16'h0000, 1'b1, plid_pkg::ST_BADPOS, 5'd5, 16'h0000},
      {plid_pkg::FUNC_DEL_POS,   5'd31, 16'h0000, 1'b1, plid_pkg::ST_BADPOS, 5'd5, 16'h0000},
      {plid_pkg::FUNC_DEL_POS,   5'd5,  16'h0000, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_DEL_POS,   5'd1,  16'h0000, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {plid_pkg::FUNC_READ,      5'd2,  16'h0000, 1'b0, plid_pkg::ST_OK,     5'd0, 16'h0000},
      {FUNC_RSVD7,               5'd31, 16'hFFFF, 1'b1, plid_pkg::ST_BADPOS, 5'd3, 16'h0000}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].f, dir_rows[i].p, dir_rows[i].v, $urandom_range(0, 12),
                dir_rows[i].typed, dir_rows[i].want);

    // random phases: mostly well-formed requests biased to fill or drain, some noise
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      kind        = (phase < 4) ? phase : $urandom_range(PH_FILL, PH_NOISE);
      drv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      rcv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      if (phase == 5 || phase == 17) hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        case (kind)
          PH_FILL: begin
            if (pick < 7) f = plid_pkg::func_t'($urandom_range(0, 2));
            else if (pick == 7) f = plid_pkg::FUNC_READ;
            else if (pick == 8) f = plid_pkg::FUNC_DEL_POS;
            else f = plid_pkg::func_t'($urandom_range(0, 7));
          end
          PH_DRAIN: begin
            if (pick < 7) f = plid_pkg::FUNC_DEL_POS;
            else if (pick == 7) f = plid_pkg::FUNC_READ;
            else if (pick == 8) f = plid_pkg::func_t'($urandom_range(0, 2));
            else f = plid_pkg::func_t'($urandom_range(0, 7));
          end
          PH_MIXED: f = plid_pkg::func_t'($urandom_range(0, 4));
          default:  f = plid_pkg::func_t'($urandom_range(0, 7));
        endcase
        lim  = (f == plid_pkg::FUNC_DEL_POS || f == plid_pkg::FUNC_READ) ?
               shadow_count : shadow_count + 1;
        pick = $urandom_range(0, 9);
        if (kind == PH_NOISE || lim == 0 || pick == 0) p = plid_pkg::pos_t'($urandom_range(0, 31));
        else if (pick == 1) p = plid_pkg::pos_t'(lim);
        else if (pick == 2) p = plid_pkg::pos_t'(1);
        else if (pick == 3) p = plid_pkg::pos_t'(lim + 1);
        else p = plid_pkg::pos_t'($urandom_range(1, lim));
        pick = $urandom_range(0, 15);
        if (pick == 0) v = '0;
        else if (pick == 1) v = '1;
        else v = plid_pkg::entry_t'($urandom);
        send_item(f, p, v, $urandom_range(0, drv_gap_max), 1'b0, '0);
      end
      // every fourth phase the sender waits for all outstanding results
      if (phase % 4 == 3) begin
        in_valid_i <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked (%0d list full, %0d bad position)",
             items_sent, results_checked, full_seen, badpos_seen);
    $display("%0d long output hold-offs, %0d errors", holds_done, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
